// ----- sv/vva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_pkg - shared types for the three-component vector ALU
// Command codes, status codes, word layouts and the 32-bit clamp.
// ----------------------------------------------------------------------------
package vva_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SQRT_STAGES   = 32;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	localparam logic signed [65:0] MAX66 = 66'sd2147483647;
	localparam logic signed [65:0] MIN66 = -66'sd2147483648;

	typedef enum logic [3:0] {
		CMD_ADD     = 4'd0,
		CMD_SUB     = 4'd1,
		CMD_SCALE   = 4'd2,
		CMD_MUL     = 4'd3,
		CMD_CROSS   = 4'd4,
		CMD_DOT     = 4'd5,
		CMD_LENGTH  = 4'd6,
		CMD_NORM    = 4'd7,
		CMD_ABS     = 4'd8,
		CMD_MAXAXIS = 4'd9,
		CMD_DET     = 4'd10,
		CMD_DROP    = 4'd11
	} cmd_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] scale;
		logic [1:0]         drop_axis;
	} in_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_scalar;
		logic [1:0]         r_axis;
		logic [1:0]         status;
	} out_t;

	typedef logic [2:0][31:0] vec_t;
	typedef logic [2:0][63:0] prod_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               flag;
	} sat_t;

	// per-item context carried alongside the root and divide pipelines
	typedef struct packed {
		cmd_t               cmd;
		logic               bad;
		vec_t               r;
		logic [2:0]         vsat;
		logic signed [31:0] scal;
		logic               ssat;
		logic [1:0]         rax;
		vec_t               mag;
		logic [2:0]         neg;
	} ctrl_t;

	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t s;
		if (v > MAX66) begin
			s.val  = 32'sh7FFF_FFFF;
			s.flag = 1'b1;
		end else if (v < MIN66) begin
			s.val  = 32'sh8000_0000;
			s.flag = 1'b1;
		end else begin
			s.val  = v[31:0];
			s.flag = 1'b0;
		end
		return s;
	endfunction

endpackage

// ----- sv/vec3_vector_alu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_vector_alu_unit - three-component fixed-point vector ALU
// Three component lanes, a merge stage, a shared root pipeline and dividers.
// ----------------------------------------------------------------------------
// Usage:
//   Present an input word on item and raise start; it is taken at the clock
//   edge where start is high and busy is low. busy stays low, so a new word
//   may enter on every cycle.
//   Each input word yields exactly one result word on result, marked by done
//   for one cycle. The receiver has no way to stall and must take it then.
// Pipeline:
//   Every command passes the lanes, the merge stage, the 32-stage square
//   root and the FRAC_BITS + 1 divide stages that normalize needs; other
//   commands ride the same pipeline so results leave in input order.
// Throughput:
//   One word per cycle, sustained.
// Reset:
//   arst_n clears the valid pipeline at once; words in flight are dropped
//   and done stays low until new words arrive.
// ----------------------------------------------------------------------------
module vec3_vector_alu_unit #(
	parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  vva_pkg::in_t  item,
	output logic          done,
	output vva_pkg::out_t result
);
	import vva_pkg::*;

	localparam int DIV_STAGES = FRAC_BITS + 1;
	localparam int LAT        = 3 + SQRT_STAGES + DIV_STAGES + 1;

	logic           go;
	logic [LAT-1:0] vld_q;
	cmd_t           cmd_in, cmd_s1, cmd_s2;
	logic [1:0]     axis_s1, axis_s2;
	vec_t           a, b;
	vec_t           res_s2, mag_s2;
	logic [2:0]     sat_s2, neg_s2;
	prod_t          prod_s2;
	ctrl_t          ctrl_s3, ctrl_sq, ctrl_dv;
	logic [63:0]    ss_s3;
	logic [31:0]    root_sq, root_dv;
	logic signed [31:0] quo [0:2];
	ctrl_t          dl_a [0:SQRT_STAGES-1];
	ctrl_t          dl_b [0:DIV_STAGES-1];
	logic [31:0]    rl_b [0:DIV_STAGES-1];
	out_t           nxt;
	logic           anysat, zero;

	assign busy   = 1'b0;
	assign go     = start && !busy;
	assign cmd_in = cmd_t'(item.cmd);
	assign a      = {item.a_z, item.a_y, item.a_x};
	assign b      = {item.b_z, item.b_y, item.b_x};

	// track words in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], go};
	end
	assign done = vld_q[LAT-1];

	// carry command and axis to the merge stage
	always_ff @(posedge clk) begin
		cmd_s1  <= cmd_in;
		cmd_s2  <= cmd_s1;
		axis_s1 <= item.drop_axis;
		axis_s2 <= axis_s1;
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		vva_lane #(
			.IDX      (g),
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.cmd    (cmd_in),
			.cmd_s1 (cmd_s1),
			.a      (a),
			.b      (b),
			.scale  (item.scale),
			.axis   (item.drop_axis),
			.res_s2 (res_s2[g]),
			.sat_s2 (sat_s2[g]),
			.prod_s2(prod_s2[g]),
			.mag_s2 (mag_s2[g]),
			.neg_s2 (neg_s2[g])
		);
	end

	vva_merge #(
		.FRAC_BITS(FRAC_BITS)
	) u_merge (
		.clk    (clk),
		.cmd_s2 (cmd_s2),
		.axis_s2(axis_s2),
		.res_s2 (res_s2),
		.sat_s2 (sat_s2),
		.prod_s2(prod_s2),
		.mag_s2 (mag_s2),
		.neg_s2 (neg_s2),
		.ctrl_s3(ctrl_s3),
		.ss_s3  (ss_s3)
	);

	vva_sqrt u_sqrt (
		.clk (clk),
		.val (ss_s3),
		.root(root_sq)
	);

	// hold context while the root forms
	always_ff @(posedge clk) begin
		dl_a[0] <= ctrl_s3;
		for (int k = 1; k < SQRT_STAGES; k++)
			dl_a[k] <= dl_a[k-1];
	end
	assign ctrl_sq = dl_a[SQRT_STAGES-1];

	for (genvar g = 0; g < 3; g++) begin : g_div
		vva_div #(
			.FRAC_BITS(FRAC_BITS)
		) u_div (
			.clk(clk),
			.mag(ctrl_sq.mag[g]),
			.neg(ctrl_sq.neg[g]),
			.len(root_sq),
			.quo(quo[g])
		);
	end

	// hold context and root while the quotients form
	always_ff @(posedge clk) begin
		dl_b[0] <= ctrl_sq;
		rl_b[0] <= root_sq;
		for (int k = 1; k < DIV_STAGES; k++) begin
			dl_b[k] <= dl_b[k-1];
			rl_b[k] <= rl_b[k-1];
		end
	end
	assign ctrl_dv = dl_b[DIV_STAGES-1];
	assign root_dv = rl_b[DIV_STAGES-1];

	// select the result word and its status
	always_comb begin
		nxt    = '0;
		anysat = 1'b0;
		zero   = 1'b0;
		case (ctrl_dv.cmd) inside
			CMD_ADD, CMD_SUB, CMD_SCALE, CMD_MUL, CMD_CROSS, CMD_ABS: begin
				nxt.r_x = ctrl_dv.r[0];
				nxt.r_y = ctrl_dv.r[1];
				nxt.r_z = ctrl_dv.r[2];
				anysat  = |ctrl_dv.vsat;
			end
			CMD_DROP: begin
				nxt.r_x = ctrl_dv.r[0];
				nxt.r_y = ctrl_dv.r[1];
				nxt.r_z = ctrl_dv.r[2];
			end
			CMD_DOT, CMD_DET: begin
				nxt.r_scalar = ctrl_dv.scal;
				anysat       = ctrl_dv.ssat;
			end
			CMD_LENGTH: begin
				if (root_dv[31]) begin
					nxt.r_scalar = 32'sh7FFF_FFFF;
					anysat       = 1'b1;
				end else begin
					nxt.r_scalar = root_dv;
				end
			end
			CMD_NORM: begin
				if (root_dv == 32'd0) begin
					zero = 1'b1;
				end else begin
					nxt.r_x = quo[0];
					nxt.r_y = quo[1];
					nxt.r_z = quo[2];
				end
			end
			CMD_MAXAXIS: nxt.r_axis = ctrl_dv.rax;
			default: ;
		endcase
		if (ctrl_dv.bad)
			nxt.status = ST_BAD;
		else if (zero)
			nxt.status = ST_ZERO;
		else if (anysat)
			nxt.status = ST_SAT;
		else
			nxt.status = ST_OK;
	end

	// output register
	always_ff @(posedge clk) begin
		result <= nxt;
	end

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> ##LAT done)
		else $error("accepted word did not complete at the fixed latency");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_ZERO) |->
		(result.r_x == 0 && result.r_y == 0 && result.r_z == 0))
		else $error("zero-length normalize returned a nonzero vector");

	a_axis_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.r_axis != 2'd0) |->
		(result.status == ST_OK && result.r_scalar == 0 && result.r_x == 0))
		else $error("axis result mixed with other fields");
`endif

endmodule

// ----- sv/vva_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_lane - one component lane of the vector ALU
// Multiplies, adds and clamps one component; exports its product and magnitude.
// ----------------------------------------------------------------------------
module vva_lane #(
	parameter int IDX       = 0,
	parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  vva_pkg::cmd_t      cmd,
	input  vva_pkg::cmd_t      cmd_s1,
	input  vva_pkg::vec_t      a,
	input  vva_pkg::vec_t      b,
	input  logic signed [31:0] scale,
	input  logic [1:0]         axis,
	output logic signed [31:0] res_s2,
	output logic               sat_s2,
	output logic signed [63:0] prod_s2,
	output logic [31:0]        mag_s2,
	output logic               neg_s2
);
	import vva_pkg::*;

	localparam int J = (IDX + 1) % 3;
	localparam int K = (IDX + 2) % 3;

	logic signed [31:0] mx, my;
	logic signed [32:0] w;
	logic [1:0]         src;
	logic signed [63:0] m0_s1, m1_s1;
	logic signed [32:0] w_s1;
	logic [31:0]        mag_s1;
	logic               neg_s1;
	logic signed [64:0] diff;
	sat_t               sv;

	// pick multiplier operands
	always_comb begin
		mx = a[IDX];
		my = b[IDX];
		case (cmd) inside
			CMD_SCALE:          my = scale;
			CMD_LENGTH, CMD_NORM: my = a[IDX];
			CMD_CROSS, CMD_DET: begin
				mx = a[J];
				my = b[K];
			end
			default: ;
		endcase
	end

	// source component for drop
	always_comb begin
		src = 2'(IDX);
		if (IDX == 0 && axis == 2'd0)
			src = 2'd1;
		if (IDX == 1 && axis <= 2'd1)
			src = 2'd2;
	end

	// add, subtract, abs and drop before the clamp
	always_comb begin
		case (cmd) inside
			CMD_ADD: w = 33'($signed(a[IDX])) + 33'($signed(b[IDX]));
			CMD_SUB: w = 33'($signed(a[IDX])) - 33'($signed(b[IDX]));
			CMD_ABS: w = a[IDX][31] ? -33'($signed(a[IDX])) : 33'($signed(a[IDX]));
			CMD_DROP: w = 33'($signed(a[src]));
			default: w = '0;
		endcase
	end

	// stage 1: products and linear results
	always_ff @(posedge clk) begin
		m0_s1  <= mx * my;
		m1_s1  <= $signed(a[K]) * $signed(b[J]);
		w_s1   <= w;
		neg_s1 <= a[IDX][31];
		mag_s1 <= a[IDX][31] ? (~a[IDX] + 32'd1) : a[IDX];
	end

	assign diff = 65'(m0_s1) - 65'(m1_s1);

	// scale back and clamp
	always_comb begin
		case (cmd_s1) inside
			CMD_ADD, CMD_SUB, CMD_ABS: sv = sat32(66'(w_s1));
			CMD_SCALE, CMD_MUL:        sv = sat32(66'(m0_s1 >>> FRAC_BITS));
			CMD_CROSS, CMD_DET:        sv = sat32(66'(diff >>> FRAC_BITS));
			CMD_DROP: begin
				sv.val  = w_s1[31:0];
				sv.flag = 1'b0;
			end
			default: sv = '0;
		endcase
	end

	// stage 2
	always_ff @(posedge clk) begin
		res_s2  <= sv.val;
		sat_s2  <= sv.flag;
		prod_s2 <= m0_s1;
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
	end

endmodule

// ----- sv/vva_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_merge - combines the three lanes
// Sums lane products for dot and length, finds the largest axis, packs context.
// ----------------------------------------------------------------------------
module vva_merge #(
	parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  vva_pkg::cmd_t  cmd_s2,
	input  logic [1:0]     axis_s2,
	input  vva_pkg::vec_t  res_s2,
	input  logic [2:0]     sat_s2,
	input  vva_pkg::prod_t prod_s2,
	input  vva_pkg::vec_t  mag_s2,
	input  logic [2:0]     neg_s2,
	output vva_pkg::ctrl_t ctrl_s3,
	output logic [63:0]    ss_s3
);
	import vva_pkg::*;

	logic signed [65:0] sum;
	sat_t               dsat;
	ctrl_t              c;

	assign sum = 66'($signed(prod_s2[0])) + 66'($signed(prod_s2[1]))
		+ 66'($signed(prod_s2[2]));
	assign dsat = sat32(sum >>> FRAC_BITS);

	always_comb begin
		c      = '0;
		c.cmd  = cmd_s2;
		c.bad  = (cmd_s2 == CMD_DROP && axis_s2 == 2'd3) || (cmd_s2 > CMD_DROP);
		c.r    = res_s2;
		c.vsat = sat_s2;
		c.mag  = mag_s2;
		c.neg  = neg_s2;
		// largest magnitude, earlier axis wins a tie
		if (mag_s2[0] < mag_s2[1])
			c.rax = (mag_s2[1] < mag_s2[2]) ? 2'd2 : 2'd1;
		else
			c.rax = (mag_s2[0] < mag_s2[2]) ? 2'd2 : 2'd0;
		case (cmd_s2) inside
			CMD_DOT: begin
				c.scal = dsat.val;
				c.ssat = dsat.flag;
			end
			CMD_DET: begin
				c.scal = res_s2[2];
				c.ssat = sat_s2[2];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		ctrl_s3 <= c;
		ss_s3   <= sum[63:0];
	end

endmodule

// ----- sv/vva_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_sqrt - pipelined integer square root
// One root bit per stage over 32 stages; floor of the root of a 64-bit word.
// ----------------------------------------------------------------------------
module vva_sqrt (
	input  logic        clk,
	input  logic [63:0] val,
	output logic [31:0] root
);
	import vva_pkg::*;

	logic [63:0] v_q  [0:SQRT_STAGES-1];
	logic [33:0] rem_q[0:SQRT_STAGES-1];
	logic [31:0] rt_q [0:SQRT_STAGES-1];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic [63:0] vi;
		logic [33:0] ri;
		logic [31:0] ti;
		logic [35:0] rn, trial;

		if (g == 0) begin : g_first
			assign vi = val;
			assign ri = '0;
			assign ti = '0;
		end else begin : g_next
			assign vi = v_q[g-1];
			assign ri = rem_q[g-1];
			assign ti = rt_q[g-1];
		end

		assign rn    = {ri, vi[63:62]};
		assign trial = {2'b00, ti, 2'b01};

		// try the next root bit
		always_ff @(posedge clk) begin
			v_q[g] <= {vi[61:0], 2'b00};
			if (rn >= trial) begin
				rem_q[g] <= 34'(rn - trial);
				rt_q[g]  <= {ti[30:0], 1'b1};
			end else begin
				rem_q[g] <= rn[33:0];
				rt_q[g]  <= {ti[30:0], 1'b0};
			end
		end
	end

	assign root = rt_q[SQRT_STAGES-1];

endmodule

// ----- sv/vva_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_div - pipelined restoring divider for normalize
// Computes sign * (mag << FRAC_BITS) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vva_div #(
	parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic [31:0]        mag,
	input  logic               neg,
	input  logic [31:0]        len,
	output logic signed [31:0] quo
);
	localparam int N = FRAC_BITS + 1;

	logic [33:0]  rem_q[0:N-1];
	logic [N-1:0] q_q  [0:N-1];
	logic [31:0]  d_q  [0:N-1];
	logic         n_q  [0:N-1];
	logic [31:0]  qs;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [33:0]  ri, rn;
		logic [N-1:0] qi;
		logic [31:0]  di;
		logic         ni, bi;

		// magnitude never exceeds len, so mag >> 1 starts below the divisor
		if (g == 0) begin : g_first
			assign ri = {3'b000, mag[31:1]};
			assign bi = mag[0];
			assign qi = '0;
			assign di = len;
			assign ni = neg;
		end else begin : g_next
			assign ri = rem_q[g-1];
			assign bi = 1'b0;
			assign qi = q_q[g-1];
			assign di = d_q[g-1];
			assign ni = n_q[g-1];
		end

		assign rn = {ri[32:0], bi};

		always_ff @(posedge clk) begin
			d_q[g] <= di;
			n_q[g] <= ni;
			if (rn >= {2'b00, di}) begin
				rem_q[g] <= rn - {2'b00, di};
				q_q[g]   <= {qi[N-2:0], 1'b1};
			end else begin
				rem_q[g] <= rn;
				q_q[g]   <= {qi[N-2:0], 1'b0};
			end
		end
	end

	// apply the sign of the component
	assign qs  = 32'(q_q[N-1]);
	assign quo = n_q[N-1] ? -$signed(qs) : $signed(qs);

endmodule
